// ----- rtl/skt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg
// Sizes, operation codes and the stored record type of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 10;
  localparam int ID_BITS    = 16;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int ENTRY_BITS = KEY_BITS + ID_BITS;

  localparam logic [1:0] FUNC_INSERT     = 2'd0;
  localparam logic [1:0] FUNC_DELETE     = 2'd1;
  localparam logic [1:0] FUNC_LIST_ALL   = 2'd2;
  localparam logic [1:0] FUNC_LIST_BELOW = 2'd3;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  id;
  } entry_t;

endpackage : skt_pkg
`default_nettype wire

// ----- rtl/sorted_key_table_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table_top
// Table of key / identifier records kept in ascending key order, with insert,
// delete, list-all and list-below operations.
// ----------------------------------------------------------------------------
// The table lives in one single-port-read memory and a small sequencer walks
// it one record at a time, presenting the address of each record (S_RD) and
// then evaluating its registered read data (S_EV); in_stall stays high until
// the last result of an operation has been loaded into the output register.
// An insert walks the records at or above the new key, a delete walks up to
// all held records and a list walks all of them, also waiting while the
// result channel is stalled. An insert into a full table or a delete that
// misses changes nothing. A list with no matching record gives one transfer
// with out_empty_res set. Every operation ends with a transfer that has
// out_last set. The table is empty after reset.
// ----------------------------------------------------------------------------
module sorted_key_table_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // operation channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_func,
  input  wire logic [skt_pkg::KEY_BITS-1:0] in_key,
  input  wire logic [skt_pkg::ID_BITS-1:0]  in_record_id,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [skt_pkg::KEY_BITS-1:0] out_key,
  output logic      [skt_pkg::ID_BITS-1:0]  out_id,
  output logic                              out_done_ok,
  output logic                              out_full_res,
  output logic                              out_empty_res,
  output logic      [skt_pkg::CNT_BITS-1:0] out_entry_count,
  output logic                              out_last
);
  import skt_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an operation
  localparam logic [1:0] S_RD   = 2'd1;  // address presented to the memory
  localparam logic [1:0] S_EV   = 2'd2;  // read data of the current record
  localparam logic [1:0] S_FIN  = 2'd3;  // final result of the operation

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          func_r, func_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [ID_BITS-1:0]  rid_r, rid_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [CNT_BITS-1:0] idx_r, idx_nxt;
  logic                ok_r, ok_nxt;
  logic                full_r, full_nxt;
  logic                found_r, found_nxt;
  // held-back list entry: emitted once the next match or the end is known
  logic                pend_v_r, pend_v_nxt;
  entry_t              pend_r, pend_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  entry_t              out_ent_r, out_ent_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic                out_full_r, out_full_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic [CNT_BITS-1:0] out_cnt_r, out_cnt_nxt;
  logic                out_last_r, out_last_nxt;

  // memory port
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  entry_t               wr_data;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [ENTRY_BITS-1:0] rd_raw;
  entry_t               rd_ent;

  logic                is_ins;
  logic                is_list;
  logic                out_free;
  logic                list_match;
  logic [CNT_BITS-1:0] idx_dec;
  logic [CNT_BITS-1:0] idx_inc;

  assign is_ins   = (func_r == FUNC_INSERT);
  assign is_list  = (func_r == FUNC_LIST_ALL) || (func_r == FUNC_LIST_BELOW);
  assign out_free = !out_valid_r || !out_stall;
  assign idx_dec  = idx_r - CNT_BITS'(1);
  assign idx_inc  = idx_r + CNT_BITS'(1);
  assign rd_ent   = entry_t'(rd_raw);

  // insert walks down reading the record below the hole, the others walk up
  assign rd_addr = is_ins ? idx_dec[ADDR_BITS-1:0] : idx_r[ADDR_BITS-1:0];

  assign list_match = (func_r == FUNC_LIST_ALL) || (rd_ent.key < key_r);

  skt_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    rid_nxt       = rid_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    ok_nxt        = ok_r;
    full_nxt      = full_r;
    found_nxt     = found_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r[ADDR_BITS-1:0];
    wr_data       = rd_ent;

    out_valid_nxt = out_valid_r && out_stall;
    out_ent_nxt   = out_ent_r;
    out_ok_nxt    = out_ok_r;
    out_full_nxt  = out_full_r;
    out_empty_nxt = out_empty_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          key_nxt    = in_key;
          rid_nxt    = in_record_id;
          ok_nxt     = 1'b0;
          full_nxt   = 1'b0;
          found_nxt  = 1'b0;
          pend_v_nxt = 1'b0;
          idx_nxt    = '0;
          state_nxt  = S_RD;
          if (in_func == FUNC_INSERT) begin
            idx_nxt = count_r;
            if (count_r == CNT_BITS'(DEPTH)) begin
              full_nxt  = 1'b1;
              state_nxt = S_FIN;
            end
          end
        end
      end

      S_RD: begin
        if (is_ins) begin
          if (idx_r == '0) begin
            // hole reached the bottom of the table
            wr_en     = 1'b1;
            wr_data   = '{key: key_r, id: rid_r};
            count_nxt = count_r + CNT_BITS'(1);
            ok_nxt    = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_EV;
          end
        end else if (idx_r == count_r) begin
          // walked past the last record
          if (!is_list) begin
            ok_nxt = found_r;
            if (found_r) begin
              count_nxt = count_r - CNT_BITS'(1);
            end
          end
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_EV;
        end
      end

      S_EV: begin
        case (func_r)
          FUNC_INSERT: begin
            wr_en = 1'b1;
            if (rd_ent.key >= key_r) begin
              // shift the record up by one and keep walking down
              idx_nxt   = idx_dec;
              state_nxt = S_RD;
            end else begin
              wr_data   = '{key: key_r, id: rid_r};
              count_nxt = count_r + CNT_BITS'(1);
              ok_nxt    = 1'b1;
              state_nxt = S_FIN;
            end
          end
          FUNC_DELETE: begin
            if (found_r) begin
              // close the gap left by the removed record
              wr_en     = 1'b1;
              wr_addr   = idx_dec[ADDR_BITS-1:0];
              idx_nxt   = idx_inc;
              state_nxt = S_RD;
            end else if (rd_ent.key == key_r) begin
              found_nxt = 1'b1;
              idx_nxt   = idx_inc;
              state_nxt = S_RD;
            end else if (rd_ent.key < key_r) begin
              idx_nxt   = idx_inc;
              state_nxt = S_RD;
            end else begin
              ok_nxt    = 1'b0;
              state_nxt = S_FIN;
            end
          end
          default: begin
            if (list_match && pend_v_r) begin
              // a later match exists, so the held entry is not the last one
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_ent_nxt   = pend_r;
                out_ok_nxt    = 1'b1;
                out_full_nxt  = 1'b0;
                out_empty_nxt = 1'b0;
                out_cnt_nxt   = count_r;
                out_last_nxt  = 1'b0;
                pend_nxt      = rd_ent;
                idx_nxt       = idx_inc;
                state_nxt     = S_RD;
              end
            end else begin
              if (list_match) begin
                pend_nxt   = rd_ent;
                pend_v_nxt = 1'b1;
              end
              idx_nxt   = idx_inc;
              state_nxt = S_RD;
            end
          end
        endcase
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = count_r;
          out_last_nxt  = 1'b1;
          out_full_nxt  = full_r;
          if (is_list) begin
            out_ent_nxt   = pend_v_r ? pend_r : '0;
            out_ok_nxt    = pend_v_r;
            out_empty_nxt = !pend_v_r;
          end else begin
            out_ent_nxt   = '0;
            out_ok_nxt    = ok_r;
            out_empty_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
      full_r      <= 1'b0;
      found_r     <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      ok_r        <= ok_nxt;
      full_r      <= full_nxt;
      found_r     <= found_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    key_r       <= key_nxt;
    rid_r       <= rid_nxt;
    idx_r       <= idx_nxt;
    pend_r      <= pend_nxt;
    out_ent_r   <= out_ent_nxt;
    out_ok_r    <= out_ok_nxt;
    out_full_r  <= out_full_nxt;
    out_empty_r <= out_empty_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_key         = out_ent_r.key;
  assign out_id          = out_ent_r.id;
  assign out_done_ok     = out_ok_r;
  assign out_full_res    = out_full_r;
  assign out_empty_res   = out_empty_r;
  assign out_entry_count = out_cnt_r;
  assign out_last        = out_last_r;

endmodule : sorted_key_table_top
`default_nettype wire

// ----- rtl/skt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_ram
// Generic single write, single read memory with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : skt_ram
`default_nettype wire
